>>> sv/csi_pkg.sv
// shared widths, register codes and result type for the cone/sphere intersection test
package csi_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int AX_W        = 16;
	localparam int AX_FRAC     = 14;
	localparam int INV_W       = 24;
	localparam int INV_FRAC    = 16;
	localparam int K_W         = 17;
	localparam int ALIGN       = 12;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = INV_W;

	localparam logic [CFG_IDX_W-1:0] REG_INV_SIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COS_SQ  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SIN_SQ  = CFG_IDX_W'(2);

	localparam logic [INV_W-1:0] INV_SIN_RST = INV_W'(131072);
	localparam logic [K_W-1:0]   COS_SQ_RST  = K_W'(49152);
	localparam logic [K_W-1:0]   SIN_SQ_RST  = K_W'(16384);

	// front end widths
	localparam int W_W   = COORD_WIDTH + 1;
	localparam int R_W   = COORD_WIDTH - 1;
	localparam int R2_W  = 2 * R_W;
	localparam int PRD_W = R_W + INV_W;
	localparam int SA_W  = COORD_WIDTH + 1 + AX_W;
	localparam int D_W   = COORD_WIDTH + 4;

	// quadratic test widths
	localparam int V_W    = D_W;
	localparam int M_W    = V_W;
	localparam int ML     = M_W / 2;
	localparam int MH     = M_W - ML;
	localparam int SQ_W   = 2 * M_W;
	localparam int LEN_W  = SQ_W + 2;
	localparam int DP_W   = V_W + AX_W;
	localparam int DOT_W  = DP_W + 2;
	localparam int DM_W   = DOT_W - 1;
	localparam int DL     = DM_W / 2;
	localparam int DH     = DM_W - DL;
	localparam int DSQ_W  = 2 * DM_W;
	localparam int LC     = (LEN_W + 2) / 3;
	localparam int LK_W   = LC + K_W;
	localparam int RHS_W  = 3 * LC + K_W + ALIGN;
	localparam int CMP_W  = (DSQ_W > RHS_W) ? DSQ_W : RHS_W;

	// pipeline depth
	localparam int PRE_ST = 4;
	localparam int QT_ST  = 7;
	localparam int NST    = PRE_ST + QT_ST + 1;

	typedef struct packed {
		logic             pos;
		logic             neg;
		logic             in_cone;
		logic [LEN_W-1:0] len2;
	} csi_qres_t;

endpackage

>>> sv/csi_quad_test.sv
// pipelined dot product, squared length and cone angle compare for one vector
module csi_quad_test (
	input  logic                                clk,
	input  logic [csi_pkg::QT_ST-1:0]           en,
	input  logic signed [csi_pkg::V_W-1:0]      vec [3],
	input  logic signed [csi_pkg::AX_W-1:0]     ax [3],
	input  logic [csi_pkg::K_W-1:0]             k,
	output csi_pkg::csi_qres_t                  res
);

	localparam int M_W   = csi_pkg::M_W;
	localparam int ML    = csi_pkg::ML;
	localparam int MH    = csi_pkg::MH;
	localparam int SQ_W  = csi_pkg::SQ_W;
	localparam int LEN_W = csi_pkg::LEN_W;
	localparam int DP_W  = csi_pkg::DP_W;
	localparam int DOT_W = csi_pkg::DOT_W;
	localparam int DM_W  = csi_pkg::DM_W;
	localparam int DL    = csi_pkg::DL;
	localparam int DH    = csi_pkg::DH;
	localparam int DSQ_W = csi_pkg::DSQ_W;
	localparam int LC    = csi_pkg::LC;
	localparam int LK_W  = csi_pkg::LK_W;
	localparam int RHS_W = csi_pkg::RHS_W;
	localparam int CMP_W = csi_pkg::CMP_W;
	localparam int ALIGN = csi_pkg::ALIGN;

	logic signed [DP_W-1:0]  prod_c [3];
	logic [M_W-1:0]          mag_c [3];
	logic signed [DP_W-1:0]  prod_s1 [3];
	logic [M_W-1:0]          mag_s1 [3];

	logic signed [DOT_W-1:0] dot_c;
	logic [MH-1:0]           h_c [3];
	logic [ML-1:0]           l_c [3];
	logic [2*MH-1:0]         hh_c [3];
	logic [MH+ML-1:0]        hl_c [3];
	logic [2*ML-1:0]         ll_c [3];
	logic signed [DOT_W-1:0] dot_s2;
	logic [2*MH-1:0]         hh_s2 [3];
	logic [MH+ML-1:0]        hl_s2 [3];
	logic [2*ML-1:0]         ll_s2 [3];

	logic [DM_W-1:0]         dmag_c;
	logic                    pos_c;
	logic                    neg_c;
	logic [SQ_W-1:0]         sq_c [3];
	logic [DM_W-1:0]         dmag_s3;
	logic                    pos_s3;
	logic                    neg_s3;
	logic [SQ_W-1:0]         sq_s3 [3];

	logic [LEN_W-1:0]        len2_c;
	logic [DH-1:0]           dh_c;
	logic [DL-1:0]           dl_c;
	logic [LEN_W-1:0]        len2_s4;
	logic [2*DH-1:0]         dhh_s4;
	logic [DH+DL-1:0]        dhl_s4;
	logic [2*DL-1:0]         dll_s4;
	logic                    pos_s4;
	logic                    neg_s4;

	logic [DSQ_W-1:0]        dsq_c;
	logic [3*LC-1:0]         len_ext_c;
	logic [LK_W-1:0]         lk_c [3];
	logic [DSQ_W-1:0]        dsq_s5;
	logic [LK_W-1:0]         lk_s5 [3];
	logic [LEN_W-1:0]        len2_s5;
	logic                    pos_s5;
	logic                    neg_s5;

	logic [RHS_W-1:0]        rhs_c;
	logic [DSQ_W-1:0]        dsq_s6;
	logic [RHS_W-1:0]        rhs_s6;
	logic [LEN_W-1:0]        len2_s6;
	logic                    pos_s6;
	logic                    neg_s6;

	logic                    in_cone_s7;
	logic [LEN_W-1:0]        len2_s7;
	logic                    pos_s7;
	logic                    neg_s7;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_c[i] = DP_W'(vec[i]) * DP_W'(ax[i]);
			mag_c[i]  = vec[i][M_W-1] ? M_W'(-vec[i]) : M_W'(vec[i]);
			h_c[i]    = mag_s1[i][M_W-1:ML];
			l_c[i]    = mag_s1[i][ML-1:0];
			hh_c[i]   = (2*MH)'(h_c[i]) * (2*MH)'(h_c[i]);
			hl_c[i]   = (MH+ML)'(h_c[i]) * (MH+ML)'(l_c[i]);
			ll_c[i]   = (2*ML)'(l_c[i]) * (2*ML)'(l_c[i]);
			sq_c[i]   = (SQ_W'(hh_s2[i]) << (2*ML)) + (SQ_W'(hl_s2[i]) << (ML+1))
				+ SQ_W'(ll_s2[i]);
		end
		dot_c  = DOT_W'(prod_s1[0]) + DOT_W'(prod_s1[1]) + DOT_W'(prod_s1[2]);
		dmag_c = dot_s2[DOT_W-1] ? DM_W'(-dot_s2) : DM_W'(dot_s2);
		pos_c  = !dot_s2[DOT_W-1] && (dot_s2 != '0);
		neg_c  = dot_s2[DOT_W-1];
		len2_c = LEN_W'(sq_s3[0]) + LEN_W'(sq_s3[1]) + LEN_W'(sq_s3[2]);
		dh_c   = dmag_s3[DM_W-1:DL];
		dl_c   = dmag_s3[DL-1:0];
		dsq_c  = (DSQ_W'(dhh_s4) << (2*DL)) + (DSQ_W'(dhl_s4) << (DL+1)) + DSQ_W'(dll_s4);
		len_ext_c = (3*LC)'(len2_s4);
		for (int j = 0; j < 3; j++) begin
			lk_c[j] = LK_W'(len_ext_c[j*LC +: LC]) * LK_W'(k);
		end
		rhs_c = (RHS_W'(lk_s5[2]) << (2*LC+ALIGN)) + (RHS_W'(lk_s5[1]) << (LC+ALIGN))
			+ (RHS_W'(lk_s5[0]) << ALIGN);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= prod_c[i];
				mag_s1[i]  <= mag_c[i];
			end
		end
		if (en[1]) begin
			dot_s2 <= dot_c;
			for (int i = 0; i < 3; i++) begin
				hh_s2[i] <= hh_c[i];
				hl_s2[i] <= hl_c[i];
				ll_s2[i] <= ll_c[i];
			end
		end
		if (en[2]) begin
			dmag_s3 <= dmag_c;
			pos_s3  <= pos_c;
			neg_s3  <= neg_c;
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= sq_c[i];
			end
		end
		if (en[3]) begin
			len2_s4 <= len2_c;
			dhh_s4  <= (2*DH)'(dh_c) * (2*DH)'(dh_c);
			dhl_s4  <= (DH+DL)'(dh_c) * (DH+DL)'(dl_c);
			dll_s4  <= (2*DL)'(dl_c) * (2*DL)'(dl_c);
			pos_s4  <= pos_s3;
			neg_s4  <= neg_s3;
		end
		if (en[4]) begin
			dsq_s5  <= dsq_c;
			len2_s5 <= len2_s4;
			pos_s5  <= pos_s4;
			neg_s5  <= neg_s4;
			for (int j = 0; j < 3; j++) begin
				lk_s5[j] <= lk_c[j];
			end
		end
		if (en[5]) begin
			dsq_s6  <= dsq_s5;
			rhs_s6  <= rhs_c;
			len2_s6 <= len2_s5;
			pos_s6  <= pos_s5;
			neg_s6  <= neg_s5;
		end
		if (en[6]) begin
			in_cone_s7 <= CMP_W'(dsq_s6) >= CMP_W'(rhs_s6);
			len2_s7    <= len2_s6;
			pos_s7     <= pos_s6;
			neg_s7     <= neg_s6;
		end
	end

	assign res.pos     = pos_s7;
	assign res.neg     = neg_s7;
	assign res.in_cone = in_cone_s7;
	assign res.len2    = len2_s7;

endmodule

>>> sv/cone_sphere_intersect.sv
// cone/sphere intersection, fully pipelined, one query per clock unless stalled
// Each item is a cone (vertex, unit axis) and a sphere (center, radius); the
// result item is one hit bit. The block accepts one item every clock unless
// the output is held with every stage full. The hit passes through 4 front-end
// stages (vertex offset, radius/sin shift with saturation, axis scaling), 7
// stages of the quadratic test that run for the shifted and the unshifted
// vector side by side, with the wide squares split into narrow partial
// products, and an output register. Each stage moves on its own when the next
// one is empty or moves, so bubbles close up while the output is held. The
// three angle registers (1/sin, cos^2, sin^2) reset to a 60 degree cone and
// must be written only while no item is in flight; cfg_ready is always high
// and writes to an unused index are ignored.
module cone_sphere_intersect (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [csi_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [csi_pkg::CFG_DATA_W-1:0]            cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [csi_pkg::COORD_WIDTH-1:0]    vertex_x,
	input  logic signed [csi_pkg::COORD_WIDTH-1:0]    vertex_y,
	input  logic signed [csi_pkg::COORD_WIDTH-1:0]    vertex_z,
	input  logic signed [csi_pkg::AX_W-1:0]           axis_x,
	input  logic signed [csi_pkg::AX_W-1:0]           axis_y,
	input  logic signed [csi_pkg::AX_W-1:0]           axis_z,
	input  logic signed [csi_pkg::COORD_WIDTH-1:0]    center_x,
	input  logic signed [csi_pkg::COORD_WIDTH-1:0]    center_y,
	input  logic signed [csi_pkg::COORD_WIDTH-1:0]    center_z,
	input  logic [csi_pkg::R_W-1:0]                   radius,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic                                      hit
);

	localparam int CW       = csi_pkg::COORD_WIDTH;
	localparam int AX_W     = csi_pkg::AX_W;
	localparam int AX_FRAC  = csi_pkg::AX_FRAC;
	localparam int INV_W    = csi_pkg::INV_W;
	localparam int INV_FRAC = csi_pkg::INV_FRAC;
	localparam int K_W      = csi_pkg::K_W;
	localparam int W_W      = csi_pkg::W_W;
	localparam int R_W      = csi_pkg::R_W;
	localparam int R2_W     = csi_pkg::R2_W;
	localparam int PRD_W    = csi_pkg::PRD_W;
	localparam int SA_W     = csi_pkg::SA_W;
	localparam int D_W      = csi_pkg::D_W;
	localparam int LEN_W    = csi_pkg::LEN_W;
	localparam int PRE_ST   = csi_pkg::PRE_ST;
	localparam int QT_ST    = csi_pkg::QT_ST;
	localparam int NST      = csi_pkg::NST;

	logic [INV_W-1:0]       inv_sin_q;
	logic [K_W-1:0]         cos_sq_q;
	logic [K_W-1:0]         sin_sq_q;

	logic [NST-1:0]         vld_q;
	logic [NST-1:0]         en;

	logic signed [CW-1:0]   vert_c [3];
	logic signed [CW-1:0]   cent_c [3];
	logic signed [AX_W-1:0] ax_c [3];

	logic signed [W_W-1:0]  w_s1 [3];
	logic signed [AX_W-1:0] a_s1 [3];
	logic [R_W-1:0]         r_s1;
	logic [PRD_W-1:0]       rs_s1;

	logic [CW-1:0]          s_c;
	logic [CW-1:0]          s_s2;
	logic [R2_W-1:0]        r2_s2;
	logic signed [W_W-1:0]  w_s2 [3];
	logic signed [AX_W-1:0] a_s2 [3];

	logic signed [SA_W-1:0] sa_s3 [3];
	logic [R2_W-1:0]        r2_s3;
	logic signed [W_W-1:0]  w_s3 [3];
	logic signed [AX_W-1:0] a_s3 [3];

	logic signed [D_W-1:0]  d_s4 [3];
	logic signed [D_W-1:0]  wx_s4 [3];
	logic signed [AX_W-1:0] a_s4 [3];
	logic [R2_W-1:0]        r2_s4;

	logic [R2_W-1:0]        r2_dly_q [QT_ST];
	csi_pkg::csi_qres_t     res_d;
	csi_pkg::csi_qres_t     res_w;
	logic                   hit_s12;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_sin_q <= csi_pkg::INV_SIN_RST;
			cos_sq_q  <= csi_pkg::COS_SQ_RST;
			sin_sq_q  <= csi_pkg::SIN_SQ_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				csi_pkg::REG_INV_SIN: begin
					inv_sin_q <= cfg_data[INV_W-1:0];
				end
				csi_pkg::REG_COS_SQ: begin
					cos_sq_q <= cfg_data[K_W-1:0];
				end
				csi_pkg::REG_SIN_SQ: begin
					sin_sq_q <= cfg_data[K_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// a stage may load when it or any stage after it has room
	always_comb begin
		for (int k = 0; k < NST; k++) begin
			en[k] = out_ready || ((vld_q | NST'((1 << k) - 1)) != '1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NST-1];
	assign hit       = hit_s12;

	assign vert_c[0] = vertex_x;
	assign vert_c[1] = vertex_y;
	assign vert_c[2] = vertex_z;
	assign cent_c[0] = center_x;
	assign cent_c[1] = center_y;
	assign cent_c[2] = center_z;
	assign ax_c[0]   = axis_x;
	assign ax_c[1]   = axis_y;
	assign ax_c[2]   = axis_z;

	// shift length saturates to the coordinate range
	assign s_c = (|rs_s1[PRD_W-1:INV_FRAC+CW]) ? '1 : rs_s1[INV_FRAC+CW-1:INV_FRAC];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				w_s1[i] <= W_W'(cent_c[i]) - W_W'(vert_c[i]);
				a_s1[i] <= ax_c[i];
			end
			r_s1  <= radius;
			rs_s1 <= PRD_W'(radius) * PRD_W'(inv_sin_q);
		end
		if (en[1]) begin
			s_s2  <= s_c;
			r2_s2 <= R2_W'(r_s1) * R2_W'(r_s1);
			for (int i = 0; i < 3; i++) begin
				w_s2[i] <= w_s1[i];
				a_s2[i] <= a_s1[i];
			end
		end
		if (en[2]) begin
			r2_s3 <= r2_s2;
			for (int i = 0; i < 3; i++) begin
				sa_s3[i] <= SA_W'(signed'({1'b0, s_s2})) * SA_W'(a_s2[i]);
				w_s3[i]  <= w_s2[i];
				a_s3[i]  <= a_s2[i];
			end
		end
		if (en[3]) begin
			r2_s4 <= r2_s3;
			for (int i = 0; i < 3; i++) begin
				d_s4[i]  <= D_W'(w_s3[i]) + D_W'(sa_s3[i] >>> AX_FRAC);
				wx_s4[i] <= D_W'(w_s3[i]);
				a_s4[i]  <= a_s3[i];
			end
		end
		if (en[PRE_ST]) begin
			r2_dly_q[0] <= r2_s4;
		end
		for (int j = 1; j < QT_ST; j++) begin
			if (en[PRE_ST+j]) begin
				r2_dly_q[j] <= r2_dly_q[j-1];
			end
		end
		if (en[NST-1]) begin
			hit_s12 <= res_d.pos && res_d.in_cone
				&& !(res_w.neg && res_w.in_cone
				&& (res_w.len2 > LEN_W'(r2_dly_q[QT_ST-1])));
		end
	end

	// shifted vertex against cos^2
	csi_quad_test u_quad_d (
		.clk (clk),
		.en  (en[PRE_ST +: QT_ST]),
		.vec (d_s4),
		.ax  (a_s4),
		.k   (cos_sq_q),
		.res (res_d)
	);

	// apex region against sin^2
	csi_quad_test u_quad_w (
		.clk (clk),
		.en  (en[PRE_ST +: QT_ST]),
		.vec (wx_s4),
		.ax  (a_s4),
		.k   (sin_sq_q),
		.res (res_w)
	);

`ifndef SYNTHESIS
	a_empty_out_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_q) && !out_ready) |-> !in_ready)
		else $error("input accepted while pipeline full and stalled");
	a_bubble_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && !in_valid) |=> !vld_q[0])
		else $error("first stage valid without an accepted item");
`endif

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the cone/sphere intersection test pipeline
`timescale 1ns / 100ps

module tb_top;

	localparam int COORD_WIDTH = csi_pkg::COORD_WIDTH;
	localparam int AX_W        = csi_pkg::AX_W;
	localparam int AX_FRAC     = csi_pkg::AX_FRAC;
	localparam int R_W         = csi_pkg::R_W;
	localparam int INV_W       = csi_pkg::INV_W;
	localparam int INV_FRAC    = csi_pkg::INV_FRAC;
	localparam int K_W         = csi_pkg::K_W;
	localparam int ALIGN       = csi_pkg::ALIGN;
	localparam int CFG_IDX_W   = csi_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W  = csi_pkg::CFG_DATA_W;
	localparam int NST         = csi_pkg::NST;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
	localparam int ONE        = 65536;
	localparam int MAX_COORD  = 32'sh7FFF_FFFF;
	localparam int MIN_COORD  = 32'sh8000_0000;
	localparam int MAX_RADIUS = 32'h7FFF_FFFF;

	typedef logic signed [127:0] acc_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] vx, vy, vz;
		logic signed [AX_W-1:0]        ax, ay, az;
		logic signed [COORD_WIDTH-1:0] cx, cy, cz;
		logic [R_W-1:0]                rad;
	} query_t;

	typedef enum {SHAPE_FRONT, SHAPE_BEHIND, SHAPE_NOISE} shape_t;
	typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COORD_WIDTH-1:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
	logic signed [AX_W-1:0] axis_x = '0, axis_y = '0, axis_z = '0;
	logic signed [COORD_WIDTH-1:0] center_x = '0, center_y = '0, center_z = '0;
	logic [R_W-1:0] radius = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;

	// angle registers as the block should hold them
	logic [INV_W-1:0] angle_inv_sin = csi_pkg::INV_SIN_RST;
	logic [K_W-1:0] angle_cos_sq = csi_pkg::COS_SQ_RST;
	logic [K_W-1:0] angle_sin_sq = csi_pkg::SIN_SQ_RST;

	bit expected_hits[$];
	int mismatch_count = 0;
	int burst_left = 0;
	int rx_left = 0;
	int unsigned rx_tick = 0;
	rx_mode_t rx_mode = RX_OPEN;

	cone_sphere_intersect uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.radius(radius),
		.out_valid(out_valid), .out_ready(out_ready), .hit(hit)
	);

	always #1 clk = ~clk;

	// exact two-stage cone test on wide signed integers
	function automatic bit cone_hit(query_t q);
		acc_t wv[3], dv[3], av[3];
		acc_t rad, shift, cap, dot_d, len_d, dot_w, len_w;
		int i;
		wv[0] = acc_t'($signed(q.cx)) - acc_t'($signed(q.vx));
		wv[1] = acc_t'($signed(q.cy)) - acc_t'($signed(q.vy));
		wv[2] = acc_t'($signed(q.cz)) - acc_t'($signed(q.vz));
		av[0] = acc_t'($signed(q.ax));
		av[1] = acc_t'($signed(q.ay));
		av[2] = acc_t'($signed(q.az));
		rad = acc_t'(q.rad);
		shift = (rad * acc_t'(angle_inv_sin)) >>> INV_FRAC;
		cap = (acc_t'(1) <<< COORD_WIDTH) - 1;
		if (shift > cap)
			shift = cap;
		for (i = 0; i < 3; i++)
			dv[i] = wv[i] + ((shift * av[i]) >>> AX_FRAC);
		dot_d = dv[0] * av[0] + dv[1] * av[1] + dv[2] * av[2];
		len_d = dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2];
		if (dot_d <= 0 || dot_d * dot_d < ((len_d * acc_t'(angle_cos_sq)) <<< ALIGN))
			return 1'b0;
		dot_w = wv[0] * av[0] + wv[1] * av[1] + wv[2] * av[2];
		len_w = wv[0] * wv[0] + wv[1] * wv[1] + wv[2] * wv[2];
		// sphere behind the apex only hits when it holds the vertex
		if (dot_w < 0 && dot_w * dot_w >= ((len_w * acc_t'(angle_sin_sq)) <<< ALIGN))
			return len_w <= rad * rad;
		return 1'b1;
	endfunction

	function automatic query_t mkq(int vx, int vy, int vz, int ax, int ay, int az,
			int cx, int cy, int cz, int rad);
		query_t q;
		q.vx = vx; q.vy = vy; q.vz = vz;
		q.ax = ax[AX_W-1:0]; q.ay = ay[AX_W-1:0]; q.az = az[AX_W-1:0];
		q.cx = cx; q.cy = cy; q.cz = cz;
		q.rad = rad[R_W-1:0];
		return q;
	endfunction

	function automatic real frand();
		return real'($urandom()) / 4294967296.0;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] to_fix(real units);
		real v;
		v = units * 65536.0;
		if (v > 2147483647.0)
			v = 2147483647.0;
		if (v < -2147483648.0)
			v = -2147483648.0;
		return $rtoi(v);
	endfunction

	// unit axis, center placed along it with a perpendicular offset; noise shape random
	function automatic query_t shaped_query(shape_t shape);
		query_t q;
		real u[3], p[3];
		real len, proj, reach, off, rad_u;
		int i;
		if (shape == SHAPE_NOISE) begin
			q.vx = $urandom(); q.vy = $urandom(); q.vz = $urandom();
			q.ax = AX_W'(int'($urandom_range(0, 32768)) - 16384);
			q.ay = AX_W'(int'($urandom_range(0, 32768)) - 16384);
			q.az = AX_W'(int'($urandom_range(0, 32768)) - 16384);
			q.cx = $urandom(); q.cy = $urandom(); q.cz = $urandom();
			q.rad = R_W'($urandom());
			return q;
		end
		do begin
			for (i = 0; i < 3; i++)
				u[i] = 2.0 * frand() - 1.0;
			len = $sqrt(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
		end while (len < 0.2);
		for (i = 0; i < 3; i++)
			u[i] = u[i] / len;
		do begin
			for (i = 0; i < 3; i++)
				p[i] = 2.0 * frand() - 1.0;
			proj = p[0] * u[0] + p[1] * u[1] + p[2] * u[2];
			for (i = 0; i < 3; i++)
				p[i] = p[i] - proj * u[i];
			len = $sqrt(p[0] * p[0] + p[1] * p[1] + p[2] * p[2]);
		end while (len < 0.1);
		for (i = 0; i < 3; i++)
			p[i] = p[i] / len;
		q.vx = $signed($urandom()) >>> 4;
		q.vy = $signed($urandom()) >>> 4;
		q.vz = $signed($urandom()) >>> 4;
		q.ax = AX_W'($rtoi(u[0] * 16384.0));
		q.ay = AX_W'($rtoi(u[1] * 16384.0));
		q.az = AX_W'($rtoi(u[2] * 16384.0));
		reach = (shape == SHAPE_BEHIND) ? -300.0 * frand() : 1500.0 * frand();
		off = (reach < 0.0 ? -reach : reach) * 2.5 * frand() + 20.0 * frand();
		rad_u = (frand() < 0.1) ? 0.0 : 400.0 * frand() * frand();
		q.cx = to_fix($signed(q.vx) / 65536.0 + reach * u[0] + off * p[0]);
		q.cy = to_fix($signed(q.vy) / 65536.0 + reach * u[1] + off * p[1]);
		q.cz = to_fix($signed(q.vz) / 65536.0 + reach * u[2] + off * p[2]);
		q.rad = R_W'(to_fix(rad_u));
		return q;
	endfunction

	// sender works in bursts with random gaps in between
	task automatic send_query(query_t q);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		vertex_x <= q.vx; vertex_y <= q.vy; vertex_z <= q.vz;
		axis_x <= q.ax; axis_y <= q.ay; axis_z <= q.az;
		center_x <= q.cx; center_y <= q.cy; center_z <= q.cz;
		radius <= q.rad;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_hits.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_angle(logic [INV_W-1:0] inv, logic [K_W-1:0] cos_sq,
			logic [K_W-1:0] sin_sq, bit poke_unused);
		wait_results_drained();
		cfg_write(csi_pkg::REG_INV_SIN, inv);
		cfg_write(csi_pkg::REG_COS_SQ, CFG_DATA_W'(cos_sq));
		if (poke_unused)
			cfg_write(REG_UNUSED, '1);
		cfg_write(csi_pkg::REG_SIN_SQ, CFG_DATA_W'(sin_sq));
		cfg_valid <= 1'b0;
	endtask

	task automatic test_degenerate_queries();
		send_query(mkq(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(mkq(0, 0, 0, 16384, 0, 0, 0, 5 * ONE, 0, 0));
		send_query(mkq(0, 0, 0, 16384, 0, 0, 0, 5 * ONE, 0, ONE));
		send_query(mkq(7 * ONE, -3 * ONE, 2 * ONE, 0, 0, 16384, 7 * ONE, -3 * ONE, 2 * ONE, 0));
		send_query(mkq(7 * ONE, -3 * ONE, 2 * ONE, 0, 0, 16384, 7 * ONE, -3 * ONE, 2 * ONE, ONE));
	endtask

	task automatic test_field_extremes();
		send_query(mkq(MAX_COORD, MAX_COORD, MAX_COORD, 16384, 16384, 16384,
			MIN_COORD, MIN_COORD, MIN_COORD, MAX_RADIUS));
		send_query(mkq(MIN_COORD, MIN_COORD, MIN_COORD, -16384, -16384, -16384,
			MAX_COORD, MAX_COORD, MAX_COORD, MAX_RADIUS));
		send_query(mkq(MIN_COORD, MAX_COORD, MIN_COORD, 16384, -16384, 0,
			MAX_COORD, MIN_COORD, MAX_COORD, MAX_RADIUS));
		send_query(mkq(MAX_COORD, MIN_COORD, MAX_COORD, -16384, 16384, -16384,
			MAX_COORD, MIN_COORD, MAX_COORD, 0));
		send_query(mkq(-1, -1, -1, -1, -1, -1, 0, 0, 0, 1));
	endtask

	// 30 degree half-angle cone along +z from the origin
	task automatic test_apex_region();
		send_query(mkq(0, 0, 0, 0, 0, 16384, 0, 0, -3 * ONE, 2 * ONE));
		send_query(mkq(0, 0, 0, 0, 0, 16384, 0, 0, -3 * ONE, 3 * ONE));
		send_query(mkq(0, 0, 0, 0, 0, 16384, 0, 0, -3 * ONE, 4 * ONE));
		send_query(mkq(0, 0, 0, 0, 0, 16384, 2 * ONE, 0, -ONE, 2 * ONE));
		send_query(mkq(0, 0, 0, 0, 0, 16384, 2 * ONE, 0, -ONE, 3 * ONE));
		send_query(mkq(0, 0, 0, 0, 0, 16384, 0, 0, 10 * ONE, 0));
		send_query(mkq(0, 0, 0, 0, 0, 16384, 5 * ONE, 0, 10 * ONE, 0));
		send_query(mkq(0, 0, 0, 0, 0, 16384, 6 * ONE, 0, 10 * ONE, 0));
		send_query(mkq(0, 0, 0, 0, 0, 16384, 6 * ONE, 0, 10 * ONE, ONE));
	endtask

	// negative axis parts floor the scaled shift; short and long axes used as given
	task automatic test_axis_rounding();
		send_query(mkq(0, 0, 0, -1, -3, -16383, 5, -7, -10 * ONE, 3));
		send_query(mkq(0, 0, 0, -16384, 1, -8191, -20 * ONE, 1, 3, 12345));
		send_query(mkq(0, 0, 0, 16384, 16384, 16384, 10 * ONE, 10 * ONE, 10 * ONE, ONE));
		send_query(mkq(ONE, ONE, ONE, 8000, 0, 0, 40 * ONE, 9 * ONE, ONE, 2 * ONE + 1));
	endtask

	task automatic test_random_queries(int count);
		int k;
		int unsigned pick;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 9);
			send_query(shaped_query(pick < 5 ? SHAPE_FRONT :
				(pick < 7 ? SHAPE_BEHIND : SHAPE_NOISE)));
		end
	endtask

	task automatic test_angle_settings();
		logic [K_W-1:0] cos_pick;
		program_angle(24'd65536, 17'd65536, 17'd0, 1'b0);
		test_random_queries(50);
		program_angle(24'd16777215, 17'd0, 17'd65536, 1'b1);
		test_random_queries(50);
		program_angle(24'd92682, 17'd32768, 17'd32768, 1'b0);
		test_random_queries(50);
		program_angle(24'd377400, 17'd63556, 17'd1980, 1'b0);
		test_random_queries(50);
		// out of range angle terms
		program_angle(24'd32768, 17'd131071, 17'd131071, 1'b0);
		test_random_queries(50);
		cos_pick = K_W'($urandom_range(0, 65536));
		program_angle(INV_W'($urandom_range(65536, 16777215)), cos_pick,
			17'd65536 - cos_pick, 1'b0);
		test_random_queries(50);
		program_angle(csi_pkg::INV_SIN_RST, csi_pkg::COS_SQ_RST, csi_pkg::SIN_SQ_RST, 1'b0);
		test_random_queries(50);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(20, 80);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:  out_ready <= 1'b1;
			RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
			default:  out_ready <= (rx_tick % 5 != 0);
		endcase
	end

	// accepted items and register writes
	always @(posedge clk) begin
		query_t seen;
		if (in_valid && in_ready) begin
			seen.vx = vertex_x; seen.vy = vertex_y; seen.vz = vertex_z;
			seen.ax = axis_x; seen.ay = axis_y; seen.az = axis_z;
			seen.cx = center_x; seen.cy = center_y; seen.cz = center_z;
			seen.rad = radius;
			expected_hits.push_back(cone_hit(seen));
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				csi_pkg::REG_INV_SIN: angle_inv_sin <= cfg_data[INV_W-1:0];
				csi_pkg::REG_COS_SQ:  angle_cos_sq <= cfg_data[K_W-1:0];
				csi_pkg::REG_SIN_SQ:  angle_sin_sq <= cfg_data[K_W-1:0];
				default: ;
			endcase
		end
	end

	// result check
	always @(posedge clk) begin
		bit want;
		if (out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result item with none pending, hit %b", $time, hit);
			end else begin
				want = expected_hits.pop_front();
				if (hit !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: hit expected %b, got %b", $time, want, hit);
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_degenerate_queries();
		test_field_extremes();
		test_apex_region();
		test_axis_rounding();
		test_random_queries(50);
		test_angle_settings();
		wait_results_drained();
		repeat (2 * NST) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
